### src/smirz_pkg.sv
// ============================================================================
// smirz_pkg
// Shared types, codes and helpers for the square matrix invert, rotate and
// zoom block.
// ============================================================================
package smirz_pkg;

    localparam int DATA_W  = 32;
    localparam int COORD_W = 5;
    localparam int SIZE_W  = 5;
    localparam int OP_W    = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Opcodes carried by an input word.
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_INVERT = 3'd2;
    localparam logic [OP_W-1:0] OP_ROTATE = 3'd3;
    localparam logic [OP_W-1:0] OP_ZOOM   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_INV,
        ST_INV_DRAIN,
        ST_GATHER,
        ST_GATHER_DRAIN,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_FINISH
    } t_state;

    // Which sweep the walker is running.
    typedef enum logic [1:0] {
        MODE_INVERT,
        MODE_GATHER,
        MODE_COPY
    } t_mode;

    typedef struct packed {
        logic  accept;
        logic  capture;
        logic  step;
        logic  walk_clear;
        logic  out_load;
        t_mode mode;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_err;
        logic walk_last;
    } t_dp_status;

    // Zero becomes one, everything else becomes zero.
    function automatic logic [DATA_W-1:0] invert_elem(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] res;
        res = (value == '0) ? DATA_W'(1) : '0;
        return res;
    endfunction

endpackage

### src/smirz_ram.sv
// ============================================================================
// smirz_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module smirz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/smirz_ctrl.sv
// ============================================================================
// smirz_ctrl
// Sequencer for the matrix block: accepts one word, steps the datapath
// through the access or sweep it needs, and hands the result to the output.
// ============================================================================
module smirz_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [smirz_pkg::OP_W-1:0]    i_opcode,
    input  logic                          i_stall,
    input  smirz_pkg::t_dp_status         i_status,
    output smirz_pkg::t_dp_cmd            o_cmd,
    output logic                          o_stall,
    output logic                          o_valid
);

    smirz_pkg::t_state r_state;
    smirz_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smirz_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            smirz_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_opcode)
                        smirz_pkg::OP_READ,
                        smirz_pkg::OP_ZOOM: begin
                            n_state = i_status.idx_err ? smirz_pkg::ST_FINISH
                                                       : smirz_pkg::ST_READ;
                        end
                        smirz_pkg::OP_INVERT: n_state = smirz_pkg::ST_INV;
                        smirz_pkg::OP_ROTATE: n_state = smirz_pkg::ST_GATHER;
                        default:              n_state = smirz_pkg::ST_FINISH;
                    endcase
                end
            end
            smirz_pkg::ST_READ: n_state = smirz_pkg::ST_FINISH;
            smirz_pkg::ST_INV: begin
                if (i_status.walk_last) begin
                    n_state = smirz_pkg::ST_INV_DRAIN;
                end
            end
            smirz_pkg::ST_INV_DRAIN: n_state = smirz_pkg::ST_FINISH;
            smirz_pkg::ST_GATHER: begin
                if (i_status.walk_last) begin
                    n_state = smirz_pkg::ST_GATHER_DRAIN;
                end
            end
            smirz_pkg::ST_GATHER_DRAIN: n_state = smirz_pkg::ST_COPY;
            smirz_pkg::ST_COPY: begin
                if (i_status.walk_last) begin
                    n_state = smirz_pkg::ST_COPY_DRAIN;
                end
            end
            smirz_pkg::ST_COPY_DRAIN: n_state = smirz_pkg::ST_FINISH;
            smirz_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = smirz_pkg::ST_IDLE;
                end
            end
            default: n_state = smirz_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath and handshake outputs.
    always_comb begin
        o_cmd            = '0;
        o_cmd.mode       = smirz_pkg::MODE_INVERT;
        n_out_valid      = r_out_valid && i_stall;
        case (r_state)
            smirz_pkg::ST_IDLE: begin
                o_cmd.accept     = i_valid;
                o_cmd.walk_clear = 1'b1;
            end
            smirz_pkg::ST_READ: o_cmd.capture = 1'b1;
            smirz_pkg::ST_INV: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = smirz_pkg::MODE_INVERT;
            end
            smirz_pkg::ST_INV_DRAIN: o_cmd.mode = smirz_pkg::MODE_INVERT;
            smirz_pkg::ST_GATHER: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = smirz_pkg::MODE_GATHER;
            end
            smirz_pkg::ST_GATHER_DRAIN: begin
                o_cmd.mode       = smirz_pkg::MODE_GATHER;
                o_cmd.walk_clear = 1'b1;
            end
            smirz_pkg::ST_COPY: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = smirz_pkg::MODE_COPY;
            end
            smirz_pkg::ST_COPY_DRAIN: o_cmd.mode = smirz_pkg::MODE_COPY;
            smirz_pkg::ST_FINISH: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_stall = (r_state != smirz_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == smirz_pkg::ST_IDLE))
        else $error("controller did not return to idle after loading a result");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smirz_pkg::ST_COPY_DRAIN) |->
            ($past(r_state) == smirz_pkg::ST_COPY && $past(i_status.walk_last)))
        else $error("copy drain entered before the last element was read");
`endif

endmodule

### src/smirz_dp.sv
// ============================================================================
// smirz_dp
// Datapath: index checks, matrix and scratch RAMs, sweep walker with its
// delayed write-back, and the result registers.
// ============================================================================
module smirz_dp #(
    parameter int MAX_SIZE = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smirz_pkg::t_dp_cmd                  i_cmd,
    input  logic [$clog2(MAX_SIZE+1)-1:0]       i_size,
    input  logic [smirz_pkg::OP_W-1:0]          i_opcode,
    input  logic [smirz_pkg::COORD_W-1:0]       i_row,
    input  logic [smirz_pkg::COORD_W-1:0]       i_col,
    input  logic signed [smirz_pkg::DATA_W-1:0] i_write_value,
    output smirz_pkg::t_dp_status               o_status,
    output logic signed [smirz_pkg::DATA_W-1:0] o_read_value,
    output logic                                o_index_error
);

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int CW    = NW + smirz_pkg::COORD_W + 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = smirz_pkg::DATA_W;
    localparam int XW    = IW + smirz_pkg::COORD_W;

    logic                           zoom;
    logic                           indexed_op;
    logic [smirz_pkg::COORD_W-1:0]  rr;
    logic [smirz_pkg::COORD_W-1:0]  cc;
    logic [XW-1:0]                  rr_w;
    logic [XW-1:0]                  cc_w;
    logic                           in_range;
    logic                           idx_err;
    logic [AW-1:0]                  dir_addr;
    logic [IW-1:0]                  nm1;

    logic [IW-1:0]                  r_wr;
    logic [IW-1:0]                  r_wc;
    logic [IW-1:0]                  n_wr;
    logic [IW-1:0]                  n_wc;
    logic                           walk_last;
    logic                           r_pend_valid;
    logic [AW-1:0]                  r_pend_addr;

    logic                           mat_we;
    logic [AW-1:0]                  mat_waddr;
    logic [DW-1:0]                  mat_wdata;
    logic [AW-1:0]                  mat_raddr;
    logic [DW-1:0]                  mat_rdata;
    logic                           scr_we;
    logic [DW-1:0]                  scr_rdata;

    logic [DW-1:0]                  r_res_value;
    logic                           r_res_err;
    logic [DW-1:0]                  r_out_value;
    logic                           r_out_err;

    // A zoomed read indexes the doubled image, so halve its coordinates.
    assign zoom       = (i_opcode == smirz_pkg::OP_ZOOM);
    assign indexed_op = (i_opcode == smirz_pkg::OP_WRITE) || (i_opcode == smirz_pkg::OP_READ)
                        || zoom;
    assign rr         = zoom ? (i_row >> 1) : i_row;
    assign cc         = zoom ? (i_col >> 1) : i_col;
    assign rr_w       = {{IW{1'b0}}, rr};
    assign cc_w       = {{IW{1'b0}}, cc};
    assign in_range   = (CW'(rr) < CW'(i_size)) && (CW'(cc) < CW'(i_size));
    assign idx_err    = indexed_op && !in_range;
    assign dir_addr   = {rr_w[IW-1:0], cc_w[IW-1:0]};
    assign nm1        = IW'(i_size - NW'(1));

    // Row-major walker over the active region.
    assign walk_last = (r_wr == nm1) && (r_wc == nm1);

    always_comb begin
        n_wr = r_wr;
        n_wc = r_wc;
        if (i_cmd.walk_clear) begin
            n_wr = '0;
            n_wc = '0;
        end else if (i_cmd.step) begin
            if (r_wc == nm1) begin
                n_wc = '0;
                n_wr = r_wr + IW'(1);
            end else begin
                n_wc = r_wc + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr         <= '0;
            r_wc         <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_wr         <= n_wr;
            r_wc         <= n_wc;
            r_pend_valid <= i_cmd.step;
        end
    end

    // The destination of every sweep is the walker position itself.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pend_addr <= {r_wr, r_wc};
        end
    end

    // Matrix RAM: direct writes on accept, sweep write-backs otherwise.
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = r_pend_addr;
        mat_wdata = scr_rdata;
        if (i_cmd.accept) begin
            mat_we    = (i_opcode == smirz_pkg::OP_WRITE) && in_range;
            mat_waddr = dir_addr;
            mat_wdata = i_write_value;
        end else if (r_pend_valid) begin
            case (i_cmd.mode)
                smirz_pkg::MODE_INVERT: begin
                    mat_we    = 1'b1;
                    mat_wdata = smirz_pkg::invert_elem(mat_rdata);
                end
                smirz_pkg::MODE_COPY: mat_we = 1'b1;
                default:              mat_we = 1'b0;
            endcase
        end
    end

    // Rotate gathers new[r][c] from old[n-1-c][r].
    always_comb begin
        mat_raddr = dir_addr;
        if (i_cmd.step) begin
            if (i_cmd.mode == smirz_pkg::MODE_GATHER) begin
                mat_raddr = {nm1 - r_wc, r_wr};
            end else begin
                mat_raddr = {r_wr, r_wc};
            end
        end
    end

    assign scr_we = r_pend_valid && (i_cmd.mode == smirz_pkg::MODE_GATHER);

    smirz_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    smirz_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (r_pend_addr),
        .i_wdata (mat_rdata),
        .i_raddr ({r_wr, r_wc}),
        .o_rdata (scr_rdata)
    );

    // Result staging and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_value <= '0;
            r_res_err   <= idx_err;
        end else if (i_cmd.capture) begin
            r_res_value <= mat_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_res_value;
            r_out_err   <= r_res_err;
        end
    end

    assign o_status.idx_err   = idx_err;
    assign o_status.walk_last = walk_last;
    assign o_read_value       = r_out_value;
    assign o_index_error      = r_out_err;

`ifndef SYNTHESIS
    a_walk_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_wr <= nm1 && r_wc <= nm1))
        else $error("sweep walker left the active region");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.accept && r_pend_valid))
        else $error("direct write collides with a sweep write-back");
`endif

endmodule

### src/square_matrix_invert_rotate_zoom.sv
// ============================================================================
// square_matrix_invert_rotate_zoom
// Square matrix store of signed 32-bit elements with write, read, invert,
// clockwise rotate and 2x zoomed read commands.
// ============================================================================
// The block holds an n x n matrix (n from the matrix_size register, 0 acting
// as 1 and values above MAX_SIZE acting as MAX_SIZE) in a single-port-read
// RAM, and returns exactly one result word for every command word. One
// command is worked on at a time; the input stalls from acceptance until its
// result has been placed in the output register, which can hold one result
// while the next command is already taken. Sweep length is set by the one
// read and one write per cycle that the matrix RAM allows: invert rewrites
// every element in place, rotate first gathers the turned matrix into a
// scratch RAM and then copies it back. The matrix_size register is written
// through its own valid/ready port, which is always ready; it may be changed
// only while no command is in flight. Elements keep their (row, col) place
// when the size changes, and an element never written reads as whatever the
// RAM holds.
// ============================================================================
module square_matrix_invert_rotate_zoom #(
    parameter int MAX_SIZE = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command words.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [smirz_pkg::OP_W-1:0]          i_opcode,
    input  logic [smirz_pkg::COORD_W-1:0]       i_row,
    input  logic [smirz_pkg::COORD_W-1:0]       i_col,
    input  logic signed [smirz_pkg::DATA_W-1:0] i_write_value,
    // Result words.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [smirz_pkg::DATA_W-1:0] o_read_value,
    output logic                                o_index_error,
    // Configuration.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smirz_pkg::SIZE_W-1:0]        i_cfg_matrix_size
);

    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int CW = NW + smirz_pkg::SIZE_W + 1;

    logic [smirz_pkg::SIZE_W-1:0] r_matrix_size;
    logic [NW-1:0]                active_size;
    smirz_pkg::t_dp_cmd           cmd;
    smirz_pkg::t_dp_status        status;

    // The register is always ready; a write simply replaces the size.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= smirz_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_matrix_size <= i_cfg_matrix_size;
        end
    end

    // Clamp the programmed size into the range the storage supports.
    always_comb begin
        if (r_matrix_size == '0) begin
            active_size = NW'(1);
        end else if (CW'(r_matrix_size) > CW'(MAX_SIZE)) begin
            active_size = NW'(MAX_SIZE);
        end else begin
            active_size = NW'(r_matrix_size);
        end
    end

    smirz_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    smirz_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_size        (active_size),
        .i_opcode      (i_opcode),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_write_value (i_write_value),
        .o_status      (status),
        .o_read_value  (o_read_value),
        .o_index_error (o_index_error)
    );

endmodule
